@@ rtl/smt_pkg.sv @@
// ----------------------------------------------------------------------------
// smt_pkg: shared types for the stepper step tracker
// Item modes, input and result item structs and the axis state record.
// ----------------------------------------------------------------------------
package smt_pkg;

	// Item modes
	typedef enum logic [2:0] {
		MODE_STEP     = 3'd0,
		MODE_MOVE     = 3'd1,
		MODE_PAUSE    = 3'd2,
		MODE_UNPAUSE  = 3'd3,
		MODE_SET_RATE = 3'd4,
		MODE_FIN_ACK  = 3'd5,
		MODE_SET_SYNC = 3'd6,
		MODE_SET_KEEP = 3'd7
	} mode_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic        dir_req;
		logic [31:0] count;
		logic [31:0] rate_req;
		logic        flag;
	} in_item_t;

	typedef struct packed {
		logic               step_pulse;
		logic               dir_level;
		logic signed [31:0] position;
		logic               finished;
		logic               moving_now;
		logic               active;
		logic               sync_pulse;
		logic               finish_event;
		logic [31:0]        rate_now;
	} out_item_t;

	// Axis bookkeeping state
	typedef struct packed {
		logic [31:0] steps_done;
		logic [31:0] steps_target;
		logic        direction_bit;
		logic [31:0] position_count;
		logic        moving_bit;
		logic        finished_bit;
		logic        keep_bit;
		logic        paused_bit;
		logic [31:0] sync_step;
		logic [31:0] rate_reg;
		logic        active_bit;
	} state_t;

	// State after reset: everything clear, move finished
	localparam state_t STATE_RESET = '{
		steps_done:     32'd0,
		steps_target:   32'd0,
		direction_bit:  1'b0,
		position_count: 32'd0,
		moving_bit:     1'b0,
		finished_bit:   1'b1,
		keep_bit:       1'b0,
		paused_bit:     1'b0,
		sync_step:      32'd0,
		rate_reg:       32'd0,
		active_bit:     1'b0
	};

endpackage

@@ rtl/smt_if.sv @@
// ----------------------------------------------------------------------------
// smt_if: valid/ready channels of the stepper step tracker
// Command channel carries input items, response channel carries results.
// ----------------------------------------------------------------------------
interface smt_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic        dir_req;
	logic [31:0] count;
	logic [31:0] rate_req;
	logic        flag;

	modport source (output valid, mode, dir_req, count, rate_req, flag, input ready);
	modport sink   (input valid, mode, dir_req, count, rate_req, flag, output ready);
endinterface

interface smt_rsp_if;
	logic               valid;
	logic               ready;
	logic               step_pulse;
	logic               dir_level;
	logic signed [31:0] position;
	logic               finished;
	logic               moving_now;
	logic               active;
	logic               sync_pulse;
	logic               finish_event;
	logic [31:0]        rate_now;

	modport source (output valid, step_pulse, dir_level, position, finished, moving_now,
		active, sync_pulse, finish_event, rate_now, input ready);
	modport sink   (input valid, step_pulse, dir_level, position, finished, moving_now,
		active, sync_pulse, finish_event, rate_now, output ready);
endinterface

@@ rtl/smt_next.sv @@
// ----------------------------------------------------------------------------
// smt_next: next-state and result logic
// Applies one item to the axis state and forms the result item.
// ----------------------------------------------------------------------------
module smt_next (
	input  smt_pkg::state_t    cur,
	input  smt_pkg::in_item_t  item,
	input  logic [31:0]        min_rate,
	output smt_pkg::state_t    nxt,
	output smt_pkg::out_item_t res
);
	import smt_pkg::*;

	logic [31:0] done_inc;
	logic [31:0] extra;
	logic [31:0] cnt_plus;
	logic [31:0] cnt_diff;
	logic        cnt_lt;
	logic        overshoot;
	logic        mv_dir;
	logic [31:0] mv_count;
	logic [31:0] mv_done;
	logic [31:0] req_rate;
	logic [31:0] clamped;
	logic        pulse;
	logic        sync;
	logic        fin_ev;

	// Shared arithmetic, evaluated in parallel
	assign done_inc  = cur.steps_done + 32'd1;
	assign extra     = cur.steps_done - cur.steps_target;
	assign cnt_plus  = item.count + extra;
	assign cnt_diff  = extra - item.count;
	assign cnt_lt    = item.count < extra;
	assign overshoot = cur.finished_bit && cur.moving_bit
		&& (cur.steps_done > cur.steps_target);
	assign req_rate  = item.rate_req;
	assign clamped   = (req_rate < min_rate) ? min_rate : req_rate;

	// Overshoot folding for a new move
	always_comb begin
		mv_dir   = item.dir_req;
		mv_count = item.count;
		mv_done  = '0;
		if (overshoot) begin
			if (item.dir_req != cur.direction_bit) begin
				mv_count = cnt_plus;
			end else if (cnt_lt) begin
				mv_dir   = ~item.dir_req;
				mv_count = cnt_diff;
			end else begin
				mv_done  = extra;
			end
		end
	end

	// State update per mode
	always_comb begin
		nxt    = cur;
		pulse  = 1'b0;
		sync   = 1'b0;
		fin_ev = 1'b0;
		case (mode_t'(item.mode))
			MODE_STEP: begin
				if (cur.active_bit) begin
					pulse = 1'b1;
					nxt.steps_done     = done_inc;
					nxt.position_count = cur.direction_bit ? cur.position_count - 32'd1
						: cur.position_count + 32'd1;
					if (!cur.finished_bit) begin
						if ((cur.sync_step != '0) && (done_inc == cur.sync_step)) begin
							sync          = 1'b1;
							nxt.sync_step = '0;
						end
						if (done_inc >= cur.steps_target) begin
							nxt.finished_bit = 1'b1;
							fin_ev           = 1'b1;
							if (!cur.keep_bit) begin
								nxt.moving_bit = 1'b0;
							end
						end
					end
				end
			end
			MODE_MOVE: begin
				nxt.steps_done    = mv_done;
				nxt.direction_bit = mv_dir;
				nxt.steps_target  = mv_count;
				nxt.keep_bit      = 1'b0;
				if (mv_count > mv_done) begin
					if (req_rate != '0) begin
						nxt.rate_reg = clamped;
					end
					nxt.moving_bit   = 1'b1;
					nxt.finished_bit = 1'b0;
				end else begin
					nxt.moving_bit   = 1'b0;
					nxt.finished_bit = 1'b1;
					fin_ev           = 1'b1;
				end
				nxt.active_bit = nxt.moving_bit && !cur.paused_bit && (mv_count != '0);
			end
			MODE_PAUSE: begin
				nxt.paused_bit = 1'b1;
				nxt.active_bit = 1'b0;
			end
			MODE_UNPAUSE: begin
				nxt.paused_bit = 1'b0;
				nxt.active_bit = cur.moving_bit && (cur.steps_target != '0);
			end
			MODE_SET_RATE: begin
				nxt.rate_reg = clamped;
			end
			MODE_FIN_ACK: begin
				// not moving, so active always recomputes to zero
				if (!cur.moving_bit) begin
					nxt.active_bit = 1'b0;
				end
			end
			MODE_SET_SYNC: begin
				nxt.sync_step = item.count;
			end
			MODE_SET_KEEP: begin
				nxt.keep_bit = item.flag;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// Result item
	always_comb begin
		res.step_pulse   = pulse;
		res.dir_level    = nxt.direction_bit;
		res.position     = $signed(nxt.position_count);
		res.finished     = nxt.finished_bit;
		res.moving_now   = nxt.moving_bit;
		res.active       = nxt.active_bit;
		res.sync_pulse   = sync;
		res.finish_event = fin_ev;
		res.rate_now     = nxt.rate_reg;
	end

endmodule

@@ rtl/smt_state.sv @@
// ----------------------------------------------------------------------------
// smt_state: axis state and minimum-rate registers
// State advances when an item leaves the input stage; min_rate is written
// through the configuration port.
// ----------------------------------------------------------------------------
module smt_state (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  smt_pkg::state_t nxt,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	output smt_pkg::state_t cur,
	output logic [31:0]     min_rate
);
	import smt_pkg::*;

	state_t      state_q;
	logic [31:0] min_rate_q;

	// Axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (en) begin
			state_q <= nxt;
		end
	end

	// Minimum rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= '0;
		end else if (cfg_we) begin
			min_rate_q <= cfg_wdata;
		end
	end

	assign cur      = state_q;
	assign min_rate = min_rate_q;

endmodule

@@ rtl/stepper_move_step_tracker.sv @@
// ----------------------------------------------------------------------------
// stepper_move_step_tracker: step and position bookkeeping for one axis
// A result passes the input register, then the result register, to rsp.
// Throughput: one item per cycle unless a held result stalls the channel;
// the state update of an item completes in the cycle it leaves the input
// register, so the next item sees it at once.
// Reset (arst_n low): state cleared, move finished, min_rate 0, channels empty.
// ----------------------------------------------------------------------------
module stepper_move_step_tracker (
	input  logic        clk,
	input  logic        arst_n,
	smt_cmd_if.sink     cmd,
	smt_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import smt_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      adv_s1;
	logic      valid_q;
	out_item_t res_q;
	out_item_t res;
	state_t    cur;
	state_t    nxt;
	logic [31:0] min_rate;

	// Handshake: item moves on when the result register is free or drains
	assign adv_s1    = valid_s1 && (!valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.mode     <= cmd.mode;
			item_s1.dir_req  <= cmd.dir_req;
			item_s1.count    <= cmd.count;
			item_s1.rate_req <= cmd.rate_req;
			item_s1.flag     <= cmd.flag;
		end
	end

	smt_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv_s1),
		.nxt       (nxt),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cur       (cur),
		.min_rate  (min_rate)
	);

	smt_next u_next (
		.cur      (cur),
		.item     (item_s1),
		.min_rate (min_rate),
		.nxt      (nxt),
		.res      (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_s1) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.step_pulse   = res_q.step_pulse;
	assign rsp.dir_level    = res_q.dir_level;
	assign rsp.position     = res_q.position;
	assign rsp.finished     = res_q.finished;
	assign rsp.moving_now   = res_q.moving_now;
	assign rsp.active       = res_q.active;
	assign rsp.sync_pulse   = res_q.sync_pulse;
	assign rsp.finish_event = res_q.finish_event;
	assign rsp.rate_now     = res_q.rate_now;

`ifndef SYNTHESIS
	// A sync pulse only comes with a step
	a_sync_with_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.sync_pulse |-> res_q.step_pulse)
		else $error("sync pulse without step");

	// A finish event leaves the move finished
	a_fin_event: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.finish_event |-> res_q.finished)
		else $error("finish event but move not finished");

	// Position only changes when an item is processed
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(cur.position_count))
		else $error("position changed without an item");

	// Result register only refills when the previous result is taken or empty
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !rsp.ready |-> !adv_s1)
		else $error("pending result overwritten");
`endif

endmodule
